// ===== design/sbh_pkg.sv =====
// Shared types and constants for the SPI master with ready handshake.
package sbh_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned BitCountW   = 4;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 16;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ByteW-1:0]   tx_byte;
    logic               last_byte;
    logic               miso_level;
    logic               ready_level;
  } item_t;

endpackage

// ===== design/spi_master_busy_handshake.sv =====
// Top level of the pin-level SPI master (mode 3, MSB first) with peripheral ready wait.
//
//   port group  dir  beat contents
//   in_*        in   load byte or tick with MISO/ready samples
//   out_*       out  pin levels and received byte, one beat per input beat
//   cfg_*       in   half_period_ticks write
//
// One beat per cycle sustained while out_tready stays high. An accepted beat sits in the
// input stage, then enters the queue and is taken from there by the engine into the
// result register, which offers its result.
// Reset: synchronous, rst_n low; select high, sclk high, mosi high, half period 1.
// A stalled out_tready fills the result register, the queue and the input stage,
// then in_tready drops.
module spi_master_busy_handshake
  import sbh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [7:0] tx_byte, [8] miso_level, [9] ready_level
  input  logic                in_tlast,   // last_byte
  input  logic                in_tuser,   // opcode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [0] sclk, [1] mosi, [2] select_n,
                                          // [10:3] rx_byte, [11] need_byte
  output logic                out_tlast,  // frame_done
  output logic                out_tuser,  // rx_valid
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ByteW-1:0]    cfg_data    // half_period_ticks
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  sbh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sbh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  sbh_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/sbh_front.sv =====
// Input stage: takes stream beats, decodes the item kind, hands entries to the queue.
module sbh_front
  import sbh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,
  input  logic               in_tlast,
  input  logic               in_tuser,
  output logic               push_valid,
  input  logic               push_ready,
  output item_t              push_item
);

  logic  stage_valid_r, stage_valid_nxt;
  item_t stage_r, stage_nxt;
  logic  in_beat;

  assign in_tready = !stage_valid_r || push_ready;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_nxt       = stage_r;
    if (stage_valid_r && push_ready) begin
      stage_valid_nxt = 1'b0;
    end
    if (in_beat) begin
      stage_valid_nxt       = 1'b1;
      stage_nxt.kind        = in_tuser ? KIND_LOAD : KIND_TICK;
      stage_nxt.tx_byte     = in_tdata[ByteW-1:0];
      stage_nxt.last_byte   = in_tlast;
      stage_nxt.miso_level  = in_tdata[ByteW];
      stage_nxt.ready_level = in_tdata[ByteW+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_r <= stage_nxt;
  end

  assign push_valid = stage_valid_r;
  assign push_item  = stage_r;

endmodule

// ===== design/sbh_queue.sv =====
// Two-entry queue between the input stage and the pin engine.
module sbh_queue
  import sbh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== design/sbh_engine.sv =====
// Pin engine: phase sequencer, shift registers, divider and result register.
module sbh_engine
  import sbh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ByteW-1:0]    cfg_data,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  item_t               pop_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_NEED = 3'd4
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [ByteW-1:0]     tx_r, tx_nxt;
  logic [ByteW-1:0]     rx_r, rx_nxt;
  logic [BitCountW-1:0] bit_r, bit_nxt, bit_inc;
  logic                 eof_r, eof_nxt;
  logic [ByteW-1:0]     div_r, div_nxt, div_inc;
  logic                 mosi_r, mosi_nxt;
  logic [ByteW-1:0]     half_r;
  logic [ByteW-1:0]     hp;
  logic                 elapsed;
  logic                 rx_valid;
  logic                 frame_done;
  logic [ByteW-1:0]     rx_out;
  logic                 out_valid_r;
  logic [OutDataW-1:0]  out_data_r;
  logic                 out_last_r, out_user_r;
  logic                 take;
  logic                 idle_nxt, need_nxt;

  assign cfg_ready = 1'b1;
  assign pop_ready = !out_valid_r || out_tready;
  assign take      = pop_valid && pop_ready;

  assign hp      = (half_r == '0) ? ByteW'(1) : half_r;
  assign div_inc = div_r + ByteW'(1);
  assign elapsed = (div_inc >= hp);
  assign bit_inc = bit_r + BitCountW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    tx_nxt     = tx_r;
    rx_nxt     = rx_r;
    bit_nxt    = bit_r;
    eof_nxt    = eof_r;
    div_nxt    = div_r;
    mosi_nxt   = mosi_r;
    rx_valid   = 1'b0;
    frame_done = 1'b0;
    rx_out     = '0;
    if (pop_item.kind == KIND_LOAD) begin
      if (phase_r == PH_IDLE || phase_r == PH_NEED) begin
        tx_nxt    = pop_item.tx_byte;
        eof_nxt   = pop_item.last_byte;
        rx_nxt    = '0;
        bit_nxt   = '0;
        div_nxt   = '0;
        phase_nxt = PH_WAIT;
      end
    end else begin
      case (phase_r)
        PH_WAIT: begin
          if (pop_item.ready_level) begin
            mosi_nxt  = tx_r[ByteW-1];
            tx_nxt    = {tx_r[ByteW-2:0], 1'b0};
            div_nxt   = '0;
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if (elapsed) begin
            rx_nxt  = {rx_r[ByteW-2:0], pop_item.miso_level};
            div_nxt = '0;
            if (bit_inc >= BitCountW'(BitsPerByte)) begin
              rx_valid = 1'b1;
              rx_out   = rx_nxt;
              bit_nxt  = '0;
              if (eof_r) begin
                frame_done = 1'b1;
                eof_nxt    = 1'b0;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_NEED;
              end
            end else begin
              bit_nxt   = bit_inc;
              phase_nxt = PH_HIGH;
            end
          end else begin
            div_nxt = div_inc;
          end
        end
        PH_HIGH: begin
          if (elapsed) begin
            mosi_nxt  = tx_r[ByteW-1];
            tx_nxt    = {tx_r[ByteW-2:0], 1'b0};
            div_nxt   = '0;
            phase_nxt = PH_LOW;
          end else begin
            div_nxt = div_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign idle_nxt = (phase_nxt == PH_IDLE);
  assign need_nxt = idle_nxt || (phase_nxt == PH_NEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tx_r        <= '0;
      rx_r        <= '0;
      bit_r       <= '0;
      eof_r       <= 1'b0;
      div_r       <= '0;
      mosi_r      <= 1'b1;
      half_r      <= ByteW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) half_r <= cfg_data;
      if (take) begin
        phase_r <= phase_nxt;
        tx_r    <= tx_nxt;
        rx_r    <= rx_nxt;
        bit_r   <= bit_nxt;
        eof_r   <= eof_nxt;
        div_r   <= div_nxt;
        mosi_r  <= mosi_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      out_data_r <= {4'd0, need_nxt, rx_out, idle_nxt, mosi_nxt, (phase_nxt != PH_LOW)};
      out_last_r <= frame_done;
      out_user_r <= rx_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule
